FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, included by hazard_peak_hold_alarm_combiner.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: hdl/hpha_pkg.sv
// ---------------------------------------------------------------------------
// hpha_pkg
// Shared types, codes and constant-divide helpers for the hazard combiner.
// ---------------------------------------------------------------------------
package hpha_pkg;

  localparam int RISK_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int NUM_HAZ = 5;

  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 184;
  localparam int OUT_TUSER_W = 3;

  localparam logic [15:0] INTERVAL_RST = 16'd60;
  localparam int          EXPIRY_ADD   = 600;

  // hazard numbering
  localparam logic [2:0] HAZ_EARTHQUAKE = 3'd0;
  localparam logic [2:0] HAZ_TSUNAMI    = 3'd4;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_DECAY  = 2'd1,
    FUNC_ASSESS = 2'd2
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [2:0]         hazard_sel;
    logic [15:0]        risk_sample;
    logic signed [27:0] lat_in;
    logic signed [28:0] lon_in;
    logic [31:0]        now_seconds;
  } item_t;

  typedef struct packed {
    logic [2:0]         hazard_out;
    logic [15:0]        probability;
    logic [1:0]         risk_class;
    logic [19:0]        magnitude;
    logic [22:0]        radius;
    logic signed [27:0] lat_out;
    logic signed [28:0] lon_out;
    logic [31:0]        detect_time;
    logic [31:0]        expiry_time;
  } result_t;

  // reciprocals for floor division, 32 fraction bits
  localparam logic [63:0] RECIP5  = (64'd1 << 32) / 5;
  localparam logic [63:0] RECIP10 = (64'd1 << 32) / 10;

  // floor(x / 5): reciprocal estimate is at most one low, one correction step
  function automatic logic [31:0] div5_u32(input logic [31:0] x);
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 64'(x) * RECIP5;
    q    = prod[63:32];
    r    = x - (q * 32'd5);
    if (r >= 32'd5) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // floor(x / 10), same scheme
  function automatic logic [31:0] div10_u32(input logic [31:0] x);
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 64'(x) * RECIP10;
    q    = prod[63:32];
    r    = x - (q * 32'd10);
    if (r >= 32'd10) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

endpackage

FILE: hdl/hpha_level_bank.sv
// ---------------------------------------------------------------------------
// hpha_level_bank
// Five peak-hold risk levels with update and decay.
// ---------------------------------------------------------------------------
module hpha_level_bank #(
  parameter int RISK_BITS = hpha_pkg::RISK_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  hpha_pkg::item_t                               item,
  output logic [hpha_pkg::NUM_HAZ-1:0][RISK_BITS-1:0]   levels
);

  logic [hpha_pkg::NUM_HAZ-1:0][RISK_BITS-1:0] levels_next;
  logic [RISK_BITS-1:0]                        sample;
  logic [31:0]                                 scaled [hpha_pkg::NUM_HAZ];
  logic [31:0]                                 quot   [hpha_pkg::NUM_HAZ];

  assign sample = RISK_BITS'(item.risk_sample);

  always_comb begin
    levels_next = levels;
    for (int i = 0; i < hpha_pkg::NUM_HAZ; i++) begin
      // earthquake and tsunami keep 4/5, others 7/10
      if (3'(i) == hpha_pkg::HAZ_EARTHQUAKE || 3'(i) == hpha_pkg::HAZ_TSUNAMI) begin
        scaled[i] = 32'(levels[i]) << 2;
        quot[i]   = hpha_pkg::div5_u32(scaled[i]);
      end else begin
        scaled[i] = 32'(levels[i]) * 32'd7;
        quot[i]   = hpha_pkg::div10_u32(scaled[i]);
      end
    end
    case (item.func)
      hpha_pkg::FUNC_UPDATE: begin
        for (int i = 0; i < hpha_pkg::NUM_HAZ; i++) begin
          if (item.hazard_sel == 3'(i) && sample > levels[i]) begin
            levels_next[i] = sample;
          end
        end
      end
      hpha_pkg::FUNC_DECAY: begin
        for (int i = 0; i < hpha_pkg::NUM_HAZ; i++) begin
          // below 0.05 clears
          if ((quot[i] * 32'd20) < (32'd1 << RISK_BITS)) begin
            levels_next[i] = '0;
          end else begin
            levels_next[i] = RISK_BITS'(quot[i]);
          end
        end
      end
      default: begin
        levels_next = levels;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
    end else if (en) begin
      levels <= levels_next;
    end
  end

endmodule

FILE: hdl/hpha_assess.sv
// ---------------------------------------------------------------------------
// hpha_assess
// Rate limiter, winner search and result formatting for assess transfers.
// ---------------------------------------------------------------------------
module hpha_assess #(
  parameter int RISK_BITS = hpha_pkg::RISK_BITS_DEF,
  parameter int TIME_BITS = hpha_pkg::TIME_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          cfg_wr_en,
  input  logic [15:0]                                   cfg_wr_data,
  input  hpha_pkg::item_t                               item,
  input  logic [hpha_pkg::NUM_HAZ-1:0][RISK_BITS-1:0]   levels,
  output logic                                          res_vld,
  output hpha_pkg::result_t                             res
);

  localparam int W10   = RISK_BITS + 4;
  localparam int W100  = RISK_BITS + 7;
  localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

  localparam logic [W10-1:0]  THR3    = W10'(3) << RISK_BITS;
  localparam logic [W10-1:0]  THR4    = W10'(4) << RISK_BITS;
  localparam logic [W10-1:0]  THR6    = W10'(6) << RISK_BITS;
  localparam logic [W10-1:0]  THR8    = W10'(8) << RISK_BITS;
  localparam logic [W100-1:0] RAD_MIN = W100'(5) << RISK_BITS;

  logic [15:0]          assess_interval;
  logic [TIME_BITS-1:0] last_time;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 take;
  logic [W10-1:0]       lvl10 [hpha_pkg::NUM_HAZ];
  logic                 found;
  logic [2:0]           best_idx;
  logic [RISK_BITS-1:0] best_lvl;
  logic [W10-1:0]       best10;
  logic [W100-1:0]      best100;
  logic [W100-1:0]      rad;
  logic [1:0]           cls;

  assign now_t = TIME_BITS'(item.now_seconds);
  assign diff  = now_t - last_time;
  assign take  = (item.func == hpha_pkg::FUNC_ASSESS) && !(now_t < last_time) &&
                 !(CMP_W'(diff) < CMP_W'(assess_interval));

  always_comb begin
    found    = 1'b0;
    best_idx = '0;
    best_lvl = '0;
    for (int i = 0; i < hpha_pkg::NUM_HAZ; i++) begin
      lvl10[i] = (W10'(levels[i]) << 3) + (W10'(levels[i]) << 1);
      // strict > keeps the earlier hazard on ties
      if (lvl10[i] > THR3 && (!found || levels[i] > best_lvl)) begin
        found    = 1'b1;
        best_idx = 3'(i);
        best_lvl = levels[i];
      end
    end
  end

  assign best10  = (W10'(best_lvl) << 3) + (W10'(best_lvl) << 1);
  assign best100 = W100'(best_lvl) * W100'(100);
  assign rad     = (best100 < RAD_MIN) ? RAD_MIN : best100;

  always_comb begin
    if (best10 > THR8) begin
      cls = 2'd3;
    end else if (best10 > THR6) begin
      cls = 2'd2;
    end else if (best10 > THR4) begin
      cls = 2'd1;
    end else begin
      cls = 2'd0;
    end
  end

  assign res_vld = take && found;

  always_comb begin
    res.hazard_out  = best_idx;
    res.probability = 16'(best_lvl);
    res.risk_class  = cls;
    res.magnitude   = 20'(best10);
    res.radius      = 23'(rad);
    res.lat_out     = item.lat_in;
    res.lon_out     = item.lon_in;
    res.detect_time = 32'(now_t);
    res.expiry_time = 32'(now_t + TIME_BITS'(hpha_pkg::EXPIRY_ADD));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assess_interval <= hpha_pkg::INTERVAL_RST;
      last_time       <= '0;
    end else begin
      if (cfg_wr_en) begin
        assess_interval <= cfg_wr_data;
      end
      if (en && take) begin
        last_time <= now_t;
      end
    end
  end

endmodule

FILE: hdl/hazard_peak_hold_alarm_combiner.sv
// ---------------------------------------------------------------------------
// hazard_peak_hold_alarm_combiner
// Peak-hold hazard levels with decay and rate-limited alarm assessment.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid/s_axis_tready    tuser: func, hazard_sel
//                                                  tdata: sample, lat, lon, time
//   m_axis    out   m_axis_tvalid/m_axis_tready    tuser: hazard_out
//                                                  tdata: probability .. expiry
//   cfg       in    cfg_wr_en                      cfg_wr_data: assess_interval
//
// One transfer per cycle while no result waits on a stalled m_axis. A transfer
// lands in the input register, is processed there (level bank and assessor)
// and, for an assess that finds a winner, lands in the result register.
// The input register takes the next transfer while a result waits, so one
// stalled result holds at most one further transfer on the input side.
// rst (synchronous) clears all levels, the last assess time, both valid
// flags, and loads assess_interval with 60.
//
module hazard_peak_hold_alarm_combiner #(
  parameter int RISK_BITS = hpha_pkg::RISK_BITS_DEF,
  parameter int TIME_BITS = hpha_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] risk_sample, [43:16] lat_in, [72:44] lon_in, [104:73] now_seconds
  input  logic [hpha_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] func, [4:2] hazard_sel
  input  logic [hpha_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] probability, [17:16] risk_class, [37:18] magnitude,
  // [60:38] radius, [88:61] lat_out, [117:89] lon_out,
  // [149:118] detect_time, [181:150] expiry_time
  output logic [hpha_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [2:0] hazard_out
  output logic [hpha_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [15:0]                         cfg_wr_data
);

  // input register
  logic                in_vld;
  hpha_pkg::item_t     in_item;
  hpha_pkg::item_t     in_item_next;

  // result register
  logic                out_vld;
  hpha_pkg::result_t   out_res;

  logic                out_free;
  logic                fire;
  logic                res_vld;
  hpha_pkg::result_t   res;

  logic [hpha_pkg::NUM_HAZ-1:0][RISK_BITS-1:0] levels;

  // unpack stream fields
  always_comb begin
    in_item_next.func        = hpha_pkg::func_t'(s_axis_tuser[1:0]);
    in_item_next.hazard_sel  = s_axis_tuser[4:2];
    in_item_next.risk_sample = s_axis_tdata[15:0];
    in_item_next.lat_in      = s_axis_tdata[43:16];
    in_item_next.lon_in      = s_axis_tdata[72:44];
    in_item_next.now_seconds = s_axis_tdata[104:73];
  end

  // the held transfer executes when the result slot is free or draining
  assign out_free      = !out_vld || m_axis_tready;
  assign fire          = in_vld && out_free;
  assign s_axis_tready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= in_item_next;
    end
  end

  hpha_level_bank #(
    .RISK_BITS (RISK_BITS)
  ) u_level_bank (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .item   (in_item),
    .levels (levels)
  );

  hpha_assess #(
    .RISK_BITS (RISK_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_assess (
    .clk         (clk),
    .rst         (rst),
    .en          (fire),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (in_item),
    .levels      (levels),
    .res_vld     (res_vld),
    .res         (res)
  );

  // result register: refilled only when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_res.hazard_out;
  assign m_axis_tdata  = {2'b00,
                          out_res.expiry_time,
                          out_res.detect_time,
                          out_res.lon_out,
                          out_res.lat_out,
                          out_res.radius,
                          out_res.magnitude,
                          out_res.risk_class,
                          out_res.probability};

  `include "assert_macros.svh"

  // a waiting transfer is never overwritten
  `ASSERT_PROP(a_in_hold, clk, rst, (in_vld && !fire) |=> (in_vld && $stable(in_item)))
  // input side closed exactly while the held transfer is blocked
  `ASSERT_NEVER(a_ready_blocked, clk, rst, in_vld && !fire && s_axis_tready)
  // results come only from assess transfers
  `ASSERT_PROP(a_res_assess, clk, rst,
               (fire && res_vld) |-> (in_item.func == hpha_pkg::FUNC_ASSESS))
  // an emitted result shows up in the result register next cycle
  `ASSERT_PROP(a_res_loaded, clk, rst, (fire && res_vld) |=> out_vld)

endmodule

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for hazard_peak_hold_alarm_combiner. Drives update,
// decay and assess transfers with random stalls on both streams. It keeps its
// own copy of the level bank and rate limiter, predicts every alarm, and
// checks each result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  // package names used by the bench
  typedef hpha_pkg::result_t result_t;

  localparam int          NUM_HAZ        = hpha_pkg::NUM_HAZ;
  localparam int          IN_TDATA_W     = hpha_pkg::IN_TDATA_W;
  localparam int          IN_TUSER_W     = hpha_pkg::IN_TUSER_W;
  localparam int          OUT_TDATA_W    = hpha_pkg::OUT_TDATA_W;
  localparam int          OUT_TUSER_W    = hpha_pkg::OUT_TUSER_W;
  localparam logic [15:0] INTERVAL_RST   = hpha_pkg::INTERVAL_RST;
  localparam int          EXPIRY_ADD     = hpha_pkg::EXPIRY_ADD;
  localparam logic [2:0]  HAZ_EARTHQUAKE = hpha_pkg::HAZ_EARTHQUAKE;
  localparam logic [2:0]  HAZ_TSUNAMI    = hpha_pkg::HAZ_TSUNAMI;
  localparam logic [1:0]  FUNC_UPDATE    = hpha_pkg::FUNC_UPDATE;
  localparam logic [1:0]  FUNC_DECAY     = hpha_pkg::FUNC_DECAY;
  localparam logic [1:0]  FUNC_ASSESS    = hpha_pkg::FUNC_ASSESS;

  // code the package enum leaves out; the block must drop it
  localparam logic [1:0] FUNC_BAD = 2'd3;

  // hazard numbers not named in the package, plus the invalid selector range
  localparam logic [2:0] HAZ_TORNADO = 3'd1;
  localparam logic [2:0] HAZ_DROUGHT = 3'd2;
  localparam logic [2:0] HAZ_FLOOD   = 3'd3;
  localparam logic [2:0] HAZ_BAD_LO  = 3'd5;
  localparam logic [2:0] HAZ_BAD_HI  = 3'd7;

  // risk classes
  localparam logic [1:0] CLASS_NORMAL   = 2'd0;
  localparam logic [1:0] CLASS_ELEVATED = 2'd1;
  localparam logic [1:0] CLASS_HIGH     = 2'd2;
  localparam logic [1:0] CLASS_CRITICAL = 2'd3;

  // Q0.16: 1.0 is 2^16, thresholds are in tenths
  localparam int unsigned FULL_SCALE      = 32'd65536;
  localparam int unsigned WATCH_TENTHS    = 3;
  localparam int unsigned ELEVATED_TENTHS = 4;
  localparam int unsigned HIGH_TENTHS     = 6;
  localparam int unsigned CRITICAL_TENTHS = 8;

  localparam logic [15:0] RISK_MAX = 16'hFFFF;

  localparam int signed LAT_MIN = -90000000;
  localparam int signed LAT_MAX = 90000000;
  localparam int signed LON_MIN = -180000000;
  localparam int signed LON_MAX = 180000000;

  // drain wait covers the input and result registers, with margin
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 325;
  localparam int MAX_REPORTS   = 10;

  // samples on and around every threshold, the clear level and full scale
  localparam logic [15:0] BOUNDARY_SAMPLES [14] = '{
    16'd0, 16'd1, 16'd3276, 16'd3277, 16'd19660, 16'd19661, 16'd26214,
    16'd26215, 16'd39321, 16'd39322, 16'd52428, 16'd52429, 16'd65534,
    16'd65535
  };

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         sel;
    logic [15:0]        sample;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic [31:0]        now;
  } hz_item_t;

  // -------------------------------------------------------------------------
  // Alarm scoreboard: mirror of the level bank and the assess rate limiter,
  // plus the queue of alarms still owed by the block.
  // -------------------------------------------------------------------------
  class alarm_scoreboard;
    logic [15:0] level [NUM_HAZ];
    logic [31:0] last_assess;
    logic [15:0] interval;
    result_t     alarms_due [$];
    int          mismatches;

    function new();
      foreach (level[i]) level[i] = '0;
      last_assess = '0;
      interval    = INTERVAL_RST;
      mismatches  = 0;
    endfunction

    // lvl / 2^16 > tenths / 10, exact
    function bit above(logic [31:0] lvl, int unsigned tenths);
      return (lvl * 32'd10) > (tenths * FULL_SCALE);
    endfunction

    function void note_input(hz_item_t it);
      logic [31:0] v;
      logic [31:0] best_lvl;
      int          best;
      result_t     r;
      case (it.op)
        FUNC_UPDATE: begin
          // peak hold; selectors past tsunami are dropped
          if (it.sel < NUM_HAZ && it.sample > level[it.sel]) begin
            level[it.sel] = it.sample;
          end
        end
        FUNC_DECAY: begin
          for (int i = 0; i < NUM_HAZ; i++) begin
            v = 32'(level[i]);
            if (i == HAZ_EARTHQUAKE || i == HAZ_TSUNAMI) begin
              v = (v * 32'd4) / 32'd5;
            end else begin
              v = (v * 32'd7) / 32'd10;
            end
            // below 0.05 snaps to zero
            if (v * 32'd20 < FULL_SCALE) begin
              v = '0;
            end
            level[i] = v[15:0];
          end
        end
        FUNC_ASSESS: begin
          // time going backwards or too soon: no result, time not recorded
          if (it.now >= last_assess && (it.now - last_assess) >= 32'(interval)) begin
            last_assess = it.now;
            best        = -1;
            best_lvl    = '0;
            // strict compare keeps the lowest hazard on a tie
            for (int i = 0; i < NUM_HAZ; i++) begin
              if (above(32'(level[i]), WATCH_TENTHS) && (best < 0 || level[i] > best_lvl)) begin
                best     = i;
                best_lvl = 32'(level[i]);
              end
            end
            if (best >= 0) begin
              r.hazard_out  = 3'(best);
              r.probability = best_lvl[15:0];
              if (above(best_lvl, CRITICAL_TENTHS)) begin
                r.risk_class = CLASS_CRITICAL;
              end else if (above(best_lvl, HIGH_TENTHS)) begin
                r.risk_class = CLASS_HIGH;
              end else if (above(best_lvl, ELEVATED_TENTHS)) begin
                r.risk_class = CLASS_ELEVATED;
              end else begin
                r.risk_class = CLASS_NORMAL;
              end
              v           = best_lvl * 32'd10;
              r.magnitude = v[19:0];
              v           = best_lvl * 32'd100;
              if (v < 32'd5 * FULL_SCALE) begin
                v = 32'd5 * FULL_SCALE;
              end
              r.radius      = v[22:0];
              r.lat_out     = it.lat;
              r.lon_out     = it.lon;
              r.detect_time = it.now;
              r.expiry_time = it.now + 32'(EXPIRY_ADD);
              alarms_due.push_back(r);
            end
            // no level above 0.3: time recorded, nothing owed
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      result_t got;
      result_t want;
      string   diff;
      got.hazard_out  = tuser[2:0];
      got.probability = tdata[15:0];
      got.risk_class  = tdata[17:16];
      got.magnitude   = tdata[37:18];
      got.radius      = tdata[60:38];
      got.lat_out     = tdata[88:61];
      got.lon_out     = tdata[117:89];
      got.detect_time = tdata[149:118];
      got.expiry_time = tdata[181:150];
      if (alarms_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected alarm transfer: hazard %0d prob %0d det %0d",
                   got.hazard_out, got.probability, got.detect_time);
        end
        return;
      end
      want = alarms_due.pop_front();
      diff = "";
      if (got.hazard_out  !== want.hazard_out)  diff = {diff, " hazard_out"};
      if (got.probability !== want.probability) diff = {diff, " probability"};
      if (got.risk_class  !== want.risk_class)  diff = {diff, " risk_class"};
      if (got.magnitude   !== want.magnitude)   diff = {diff, " magnitude"};
      if (got.radius      !== want.radius)      diff = {diff, " radius"};
      if (got.lat_out     !== want.lat_out)     diff = {diff, " lat_out"};
      if (got.lon_out     !== want.lon_out)     diff = {diff, " lon_out"};
      if (got.detect_time !== want.detect_time) diff = {diff, " detect_time"};
      if (got.expiry_time !== want.expiry_time) diff = {diff, " expiry_time"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("alarm mismatch in%s", diff);
          $display("  want haz %0d prob %0d cls %0d mag %0d rad %0d lat %0d lon %0d det %0d exp %0d",
                   want.hazard_out, want.probability, want.risk_class, want.magnitude,
                   want.radius, want.lat_out, want.lon_out, want.detect_time,
                   want.expiry_time);
          $display("  got  haz %0d prob %0d cls %0d mag %0d rad %0d lat %0d lon %0d det %0d exp %0d",
                   got.hazard_out, got.probability, got.risk_class, got.magnitude,
                   got.radius, got.lat_out, got.lon_out, got.detect_time,
                   got.expiry_time);
        end
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and its signals
  // -------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [15:0] risk_sample, [43:16] lat_in, [72:44] lon_in, [104:73] now_seconds
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [1:0] func, [4:2] hazard_sel
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [15:0] probability, [17:16] risk_class, [37:18] magnitude, [60:38] radius,
  // [88:61] lat_out, [117:89] lon_out, [149:118] detect_time,
  // [181:150] expiry_time
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [2:0] hazard_out
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_wr_en;
  logic [15:0]            cfg_wr_data;

  alarm_scoreboard sb = new();

  // stimulus time line: assess times walk forward along it
  logic [31:0] walk_s;
  logic [15:0] last_sample;
  // last stretch of the run: neither side idles
  bit          quiet_tail;

  hazard_peak_hold_alarm_combiner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop; far beyond the slowest correct run
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side monitor. Everything the bench drives changes through
  // nonblocking updates, so values read here are the ones at the edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Result side back-pressure: random stall bursts between random ready
  // stretches. One nonblocking update per edge at most.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Driver tasks
  // -------------------------------------------------------------------------
  function automatic hz_item_t mk(logic [1:0] op, logic [2:0] sel, logic [15:0] sample,
                                  int signed lat, int signed lon, logic [31:0] now);
    hz_item_t it;
    it.op     = op;
    it.sel    = sel;
    it.sample = sample;
    it.lat    = 28'(lat);
    it.lon    = 29'(lon);
    it.now    = now;
    return it;
  endfunction

  // Present one item and hold it until the transfer. tvalid stays high on
  // return so back-to-back items never drop it.
  task automatic send_item(input hz_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.now, it.lon, it.lat, it.sample};
    s_axis_tuser  <= {it.sel, it.op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic idle_for(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every owed alarm is out, then let the pipe empty:
  // an assess that owes nothing may still be in flight.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.alarms_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.interval = value;
  endtask

  // Random item. Mostly updates and well-spaced assesses so alarms keep
  // firing; the rest is decays, too-soon or backwards assesses, bad
  // selectors and the unused function code.
  task automatic random_item(output hz_item_t it);
    int unsigned pick;
    int unsigned k;
    logic [31:0] gap;
    pick      = $urandom_range(0, 99);
    it.sel    = 3'($urandom_range(0, 7));
    it.sample = 16'($urandom());
    it.lat    = 28'(int'($urandom_range(0, 180000000)) + LAT_MIN);
    it.lon    = 29'(int'($urandom_range(0, 360000000)) + LON_MIN);
    it.now    = $urandom();
    gap       = 32'(sb.interval);
    if (pick < 45) begin
      it.op = FUNC_UPDATE;
      if ($urandom_range(0, 99) < 93) begin
        it.sel = 3'($urandom_range(0, NUM_HAZ - 1));
      end
      k = $urandom_range(0, 99);
      if (k < 25) begin
        it.sample = BOUNDARY_SAMPLES[$urandom_range(0, 13)];
      end else if (k < 40) begin
        // repeat a sample so levels tie
        it.sample = last_sample;
      end
      last_sample = it.sample;
    end else if (pick < 60) begin
      it.op = FUNC_DECAY;
    end else if (pick < 93) begin
      it.op = FUNC_ASSESS;
      k = $urandom_range(0, 99);
      if (k < 70) begin
        walk_s = walk_s + gap + $urandom_range(0, gap / 4 + 30);
        it.now = walk_s;
      end else if (k < 75) begin
        // long silence; also walks the upper time bits
        walk_s = walk_s + gap + $urandom_range(0, 32'd1 << 24);
        it.now = walk_s;
      end else if (k < 90) begin
        // usually inside the interval
        walk_s = walk_s + $urandom_range(0, gap);
        it.now = walk_s;
      end else begin
        // clock went backwards
        it.now = (walk_s > 32'd1000) ? walk_s - $urandom_range(1, 1000) : walk_s / 2;
      end
    end else begin
      it.op = FUNC_BAD;
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    hz_item_t    it;
    int          idle_pct;
    logic [15:0] phase_interval;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    quiet_tail    = 1'b0;
    walk_s        = '0;
    last_sample   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset interval of 60 s.
    // too soon after time zero: dropped
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd0));
    // accepted, every level zero: no threat, time recorded
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd60));
    send_item(mk(FUNC_UPDATE, HAZ_EARTHQUAKE, RISK_MAX, 0, 0, 32'd0));
    // lower sample: peak hold keeps full scale
    send_item(mk(FUNC_UPDATE, HAZ_EARTHQUAKE, 16'd100, 0, 0, 32'd0));
    send_item(mk(FUNC_UPDATE, HAZ_TSUNAMI, RISK_MAX, 0, 0, 32'd0));
    // selectors past tsunami are dropped
    send_item(mk(FUNC_UPDATE, HAZ_BAD_LO, RISK_MAX, 0, 0, 32'd0));
    send_item(mk(FUNC_UPDATE, HAZ_BAD_HI, RISK_MAX, 0, 0, 32'd0));
    // unused function code with every field bit set
    send_item(mk(FUNC_BAD, HAZ_BAD_HI, RISK_MAX, -1, -1, 32'hFFFF_FFFF));
    // earthquake and tsunami tie at full scale: earthquake wins
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, LAT_MIN, LON_MAX, 32'd120));
    // backwards, then one second short of the interval
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd100));
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd179));
    send_item(mk(FUNC_DECAY, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd0));
    // just above and just below 0.3, and just above 0.8 for flood
    send_item(mk(FUNC_UPDATE, HAZ_TORNADO, 16'd19661, 0, 0, 32'd0));
    send_item(mk(FUNC_UPDATE, HAZ_DROUGHT, 16'd19660, 0, 0, 32'd0));
    send_item(mk(FUNC_UPDATE, HAZ_FLOOD, 16'd52429, 0, 0, 32'd0));
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, LAT_MAX, LON_MIN, 32'd180));
    send_item(mk(FUNC_DECAY, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd0));
    send_item(mk(FUNC_UPDATE, HAZ_TORNADO, 16'd0, 0, 0, 32'd0));
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, 0, 0, 32'd240));
    walk_s = 32'd300;

    // Random phases, each under its own interval: zero, the maximum, one,
    // a random value, a small random value, and back to 60 for the tail.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       phase_interval = 16'd0;
        1:       phase_interval = 16'hFFFF;
        2:       phase_interval = 16'd1;
        3:       phase_interval = 16'($urandom_range(2, 65534));
        4:       phase_interval = 16'($urandom_range(2, 300));
        default: phase_interval = INTERVAL_RST;
      endcase
      quiet_tail = (p == RANDOM_PHASES - 1);
      // phase 1 and the tail run the sender flat out
      idle_pct = (p == 1 || quiet_tail) ? 0 : 10 + 8 * p;
      write_interval(phase_interval);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // in phase 2, hold off mid-phase until every owed alarm has come back
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          drain();
        end
        if ($urandom_range(0, 99) < idle_pct) begin
          idle_for($urandom_range(1, 6));
        end
        random_item(it);
        send_item(it);
      end
    end

    // Expiry wrap at the top of the time range. Placed last: once the
    // recorded time is this high every earlier time reads as backwards.
    send_item(mk(FUNC_UPDATE, HAZ_DROUGHT, RISK_MAX, 0, 0, 32'd0));
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, LAT_MAX, LON_MAX, 32'hFFFF_FE00));
    send_item(mk(FUNC_ASSESS, HAZ_EARTHQUAKE, 16'd0, LAT_MIN, LON_MIN, 32'hFFFF_FFFF));

    s_axis_tvalid <= 1'b0;
    while (sb.alarms_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.alarms_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
